[hdl/rchf_pkg.sv]
// Shared types, widths and saturation helpers for the resonant highpass filter.
package rchf_pkg;

    localparam int SMP_W   = 16;                  // audio sample width
    localparam int CFG_W   = 16;                  // coefficient register width
    localparam int STG_W   = 24;                  // stage value width
    localparam int TGT_W   = 30;                  // stage target width (sample plus feedback)
    localparam int DIFF_W  = TGT_W + 1;           // target minus stage
    localparam int PROD_W  = CFG_W + 1 + DIFF_W;  // coefficient times difference
    localparam int DELTA_W = PROD_W - CFG_W;      // product after the Q0.16 shift
    localparam int SUM_W   = DELTA_W + 1;         // stage plus delta
    localparam int FBD_W   = STG_W + 1;           // stage one minus stage two
    localparam int FBP_W   = CFG_W + 1 + FBD_W;   // gain times that difference
    localparam int FB_SH   = 12;                  // Q4.12 gain shift
    localparam int CUT_SH  = 16;                  // Q0.16 coefficient shift

    localparam logic [CFG_W-1:0] CUTOFF_RESET = 16'd65470;
    localparam logic [CFG_W-1:0] GAIN_RESET   = 16'd0;

    localparam logic signed [SUM_W-1:0] STG_MAX_S = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] STG_MIN_S = -SUM_W'(8388608);
    localparam logic signed [FBD_W-1:0] OUT_MAX_S = FBD_W'(32767);
    localparam logic signed [FBD_W-1:0] OUT_MIN_S = -FBD_W'(32768);

    // Register indexes on the configuration port
    typedef enum logic {
        REG_CUTOFF = 1'b0,
        REG_GAIN   = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FB,
        ST_RUN,
        ST_WAIT,
        ST_OUT
    } t_state;

    // Control handed to each stage cell
    typedef struct packed {
        logic go;
        logic clr;
    } t_cell_ctl;

    function automatic logic signed [STG_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        logic signed [STG_W-1:0] r;
        if (v > STG_MAX_S) begin
            r = STG_MAX_S[STG_W-1:0];
        end else if (v < STG_MIN_S) begin
            r = STG_MIN_S[STG_W-1:0];
        end else begin
            r = v[STG_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [FBD_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > OUT_MAX_S) begin
            r = OUT_MAX_S[SMP_W-1:0];
        end else if (v < OUT_MIN_S) begin
            r = OUT_MIN_S[SMP_W-1:0];
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/resonant_cascade_highpass_filter_unit.sv]
// Top level of the resonant three-pole cascade highpass filter.
// Filter beat: after accept the feedback is formed, then the stage one target is registered,
// then the three stage cells run one after another and the result is loaded for output.
// Clear beat: accept goes straight to the output state; a new input is accepted only in idle.
// Synchronous active-low reset zeroes the stages, loads register defaults, empties output.
// A stalled output holds the sequencer in its output state until the result is taken.
module resonant_cascade_highpass_filter_unit import rchf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [2:0]        i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready,
    // input stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [SMP_W-1:0]  i_s_axis_tdata,   // [15:0] sample_in
    input  logic              i_s_axis_tuser,   // [0] op (1 = clear stages)
    // output stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [SMP_W-1:0]  o_m_axis_tdata    // [15:0] sample_out
);

    // configuration registers
    logic [CFG_W-1:0] r_cutoff;
    logic [CFG_W-1:0] r_gain;
    logic             w_cfg_wr;
    t_reg_idx         w_cfg_idx;

    assign o_pready  = 1'b1;
    assign w_cfg_wr  = i_psel & i_penable & i_pwrite;
    assign w_cfg_idx = t_reg_idx'(i_paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
            r_gain   <= GAIN_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_CUTOFF: r_cutoff <= i_pwdata[CFG_W-1:0];
                REG_GAIN:   r_gain   <= i_pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_CUTOFF: o_prdata = {{(32-CFG_W){1'b0}}, r_cutoff};
            REG_GAIN:   o_prdata = {{(32-CFG_W){1'b0}}, r_gain};
            default:    o_prdata = '0;
        endcase
    end

    // sequencer
    t_state r_state;
    t_state n_state;

    logic w_accept;
    logic w_out_free;
    logic w_fb_load;
    logic w_tgt_load;
    logic w_out_load;
    logic w_go1;
    logic w_clr;

    logic                    r_op;
    logic signed [SMP_W-1:0] r_x;
    logic signed [FBP_W-1:0] r_fb_prod;
    logic signed [TGT_W-1:0] r_target;
    logic                    r_ovalid;
    logic [SMP_W-1:0]        r_odata;

    logic signed [STG_W-1:0] w_s1;
    logic signed [STG_W-1:0] w_s2;
    logic signed [STG_W-1:0] w_s3;
    logic                    w_done1;
    logic                    w_done2;
    logic                    w_done3;

    assign w_accept   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_s_axis_tuser ? ST_OUT : ST_FB;
                end
            end
            ST_FB:   n_state = ST_RUN;
            ST_RUN:  n_state = ST_WAIT;
            ST_WAIT: begin
                if (w_done3) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        w_fb_load       = (r_state == ST_IDLE) && w_accept;
        w_tgt_load      = (r_state == ST_FB);
        w_go1           = (r_state == ST_RUN);
        w_clr           = (r_state == ST_OUT) && r_op;
        w_out_load      = (r_state == ST_OUT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // resonance feedback: gain times (stage one - stage two) from before this beat
    logic signed [FBD_W-1:0] w_fb_diff;
    logic signed [FBP_W-1:0] w_fb_prod;
    logic signed [FBP_W-1:0] w_fb_rnd;
    logic signed [TGT_W-1:0] w_fb;

    assign w_fb_diff = {w_s1[STG_W-1], w_s1} - {w_s2[STG_W-1], w_s2};
    assign w_fb_prod = $signed({1'b0, r_gain}) * w_fb_diff;
    assign w_fb_rnd  = r_fb_prod + FBP_W'(1 << (FB_SH - 1));
    assign w_fb      = w_fb_rnd[FB_SH +: TGT_W];

    always_ff @(posedge i_clk) begin
        if (w_fb_load) begin
            r_op      <= i_s_axis_tuser;
            r_x       <= $signed(i_s_axis_tdata);
            r_fb_prod <= w_fb_prod;
        end
        if (w_tgt_load) begin
            // stage one target: sample plus rounded feedback
            r_target <= {{(TGT_W-SMP_W){r_x[SMP_W-1]}}, r_x} + w_fb;
        end
    end

    // chain of stage cells; the done pulse of cells one and two starts the next cell
    t_cell_ctl w_ctl1;
    t_cell_ctl w_ctl2;
    t_cell_ctl w_ctl3;
    logic signed [TGT_W-1:0] w_tgt2;
    logic signed [TGT_W-1:0] w_tgt3;

    assign w_ctl1 = '{go: w_go1,   clr: w_clr};
    assign w_ctl2 = '{go: w_done1, clr: w_clr};
    assign w_ctl3 = '{go: w_done2, clr: w_clr};
    assign w_tgt2 = {{(TGT_W-STG_W){w_s1[STG_W-1]}}, w_s1};
    assign w_tgt3 = {{(TGT_W-STG_W){w_s2[STG_W-1]}}, w_s2};

    rchf_cell u_cell1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl1),
        .i_coeff  (r_cutoff),
        .i_target (r_target),
        .o_stage  (w_s1),
        .o_done   (w_done1)
    );

    rchf_cell u_cell2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl2),
        .i_coeff  (r_cutoff),
        .i_target (w_tgt2),
        .o_stage  (w_s2),
        .o_done   (w_done2)
    );

    rchf_cell u_cell3 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl3),
        .i_coeff  (r_cutoff),
        .i_target (w_tgt3),
        .o_stage  (w_s3),
        .o_done   (w_done3)
    );

    // highpass output: sample minus stage three, or zero after a clear
    logic signed [FBD_W-1:0] w_y_diff;

    assign w_y_diff = {{(FBD_W-SMP_W){r_x[SMP_W-1]}}, r_x} - {w_s3[STG_W-1], w_s3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_odata <= r_op ? '0 : sat16(w_y_diff);
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

[hdl/rchf_cell.sv]
// One one-pole lowpass stage cell: multiply on go, update the stage the cycle after.
module rchf_cell import rchf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctl               i_ctl,
    input  logic [CFG_W-1:0]        i_coeff,
    input  logic signed [TGT_W-1:0] i_target,
    output logic signed [STG_W-1:0] o_stage,
    output logic                    o_done
);

    logic signed [STG_W-1:0]   r_stage;
    logic                      r_ph;
    logic                      r_done;
    logic signed [PROD_W-1:0]  r_prod;

    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_rnd;
    logic signed [DELTA_W-1:0] w_delta;
    logic signed [SUM_W-1:0]   w_sum;

    assign w_diff  = {i_target[TGT_W-1], i_target}
                   - {{(DIFF_W-STG_W){r_stage[STG_W-1]}}, r_stage};
    assign w_prod  = $signed({1'b0, i_coeff}) * w_diff;
    // round half up, then drop the Q0.16 fraction
    assign w_rnd   = r_prod + PROD_W'(1 << (CUT_SH - 1));
    assign w_delta = w_rnd[PROD_W-1:CUT_SH];
    assign w_sum   = {{(SUM_W-STG_W){r_stage[STG_W-1]}}, r_stage} + {w_delta[DELTA_W-1], w_delta};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_ph    <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_ctl.clr) begin
            r_stage <= '0;
            r_ph    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_ph   <= i_ctl.go;
            r_done <= r_ph;
            if (r_ph) begin
                r_stage <= sat24(w_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.go) begin
            r_prod <= w_prod;
        end
    end

    assign o_stage = r_stage;
    assign o_done  = r_done;

endmodule

[test/rchf_checker.sv]
// Scoreboard for the resonant cascade highpass filter: tracks registers, predicts, compares.
`timescale 1ns / 100ps
module rchf_checker import rchf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [2:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    input  logic             i_pready,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [SMP_W-1:0] i_s_tdata,   // [15:0] sample_in
    input  logic             i_s_tuser,   // [0] op (1 = clear stages)
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [SMP_W-1:0] i_m_tdata,   // [15:0] sample_out
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    localparam longint POLE_HI = 64'sd8388607;
    localparam longint POLE_LO = -64'sd8388608;
    localparam longint OUT_HI  = 64'sd32767;
    localparam longint OUT_LO  = -64'sd32768;
    localparam int     MAX_MSGS = 30;

    typedef struct {
        logic [SMP_W-1:0] sample_out;
        int               beat_no;
    } t_hp_due;

    logic [CFG_W-1:0]        cutoff;
    logic [CFG_W-1:0]        gain;
    logic signed [STG_W-1:0] pole1;
    logic signed [STG_W-1:0] pole2;
    logic signed [STG_W-1:0] pole3;
    t_hp_due                 hp_due[$];
    int                      beats_in = 0;
    int                      fails = 0;
    int                      checked = 0;

    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Move one pole toward its target by the cutoff fraction.
    function automatic logic signed [STG_W-1:0] glide(input logic signed [STG_W-1:0] st,
                                                      input longint diff);
        longint delta;
        delta = round_half_up(longint'(cutoff) * diff, CUT_SH);
        return STG_W'(clip(longint'(st) + delta, POLE_LO, POLE_HI));
    endfunction

    function automatic logic [SMP_W-1:0] highpass_step(input logic clr,
                                                       input logic signed [SMP_W-1:0] x);
        longint fb;
        if (clr) begin
            pole1 = '0;
            pole2 = '0;
            pole3 = '0;
            return '0;
        end
        // resonance uses the poles from before this sample
        fb    = round_half_up(longint'(gain) * (longint'(pole1) - longint'(pole2)), FB_SH);
        pole1 = glide(pole1, longint'(x) - longint'(pole1) + fb);
        pole2 = glide(pole2, longint'(pole1) - longint'(pole2));
        pole3 = glide(pole3, longint'(pole2) - longint'(pole3));
        return SMP_W'(clip(longint'(x) - longint'(pole3), OUT_LO, OUT_HI));
    endfunction

    task automatic flag_mismatch(input string msg);
        fails++;
        if (fails <= MAX_MSGS) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_hp_due due;
        if (!i_rst_n) begin
            cutoff = CUTOFF_RESET;
            gain   = GAIN_RESET;
            pole1  = '0;
            pole2  = '0;
            pole3  = '0;
            hp_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_CUTOFF, 2'b00}) begin
                    cutoff = i_pwdata[CFG_W-1:0];
                end else if (i_paddr == {REG_GAIN, 2'b00}) begin
                    gain = i_pwdata[CFG_W-1:0];
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (hp_due.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                            $signed(i_m_tdata)));
                end else begin
                    due = hp_due.pop_front();
                    checked++;
                    if (i_m_tdata !== due.sample_out) begin
                        flag_mismatch($sformatf("beat %0d sample_out got %0d expected %0d",
                                                due.beat_no, $signed(i_m_tdata),
                                                $signed(due.sample_out)));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                due.sample_out = highpass_step(i_s_tuser, i_s_tdata);
                due.beat_no    = beats_in;
                beats_in++;
                hp_due.push_back(due);
            end
        end
        o_pending    <= hp_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

[test/tb_resonant_cascade_highpass_filter_unit.sv]
// Stimulus and verdict for the resonant three-pole cascade highpass filter.
`timescale 1ns / 100ps
module tb_resonant_cascade_highpass_filter_unit;
    import rchf_pkg::*;

    localparam int RAND_BEATS   = 1850;
    localparam int N_SETTINGS   = 8;
    localparam int LONG_HOLD    = 300;   // cycles the receiver refuses results
    localparam int TAIL_CYCLES  = 12;    // covers a filter beat plus margin
    localparam int TIMEOUT_NS   = 6_000_000;

    logic             clk;
    logic             rst_n    = 1'b0;
    logic             psel     = 1'b0;
    logic             penable  = 1'b0;
    logic             pwrite   = 1'b0;
    logic [2:0]       paddr    = '0;
    logic [31:0]      pwdata   = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [SMP_W-1:0] s_tdata  = '0;    // [15:0] sample_in
    logic             s_tuser  = 1'b0;  // [0] op (1 = clear stages)
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [SMP_W-1:0] m_tdata;          // [15:0] sample_out

    int fail_count;
    int pending;
    int checked;

    // Idle control shared between the stimulus and the result sink
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit rx_hold_req = 1'b0;

    int n_beats = 0;
    int n_clears = 0;
    int n_reg_writes = 0;

    resonant_cascade_highpass_filter_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    rchf_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("tb_resonant_cascade_highpass_filter_unit NOT OK");
        $finish;
    end

    // Result sink: draw a stall per result, take one beat, repeat.
    // A hold request stalls it for a long stretch so the block backs up.
    initial begin : result_sink
        int stall;
        @(posedge clk iff rst_n);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 10);
            if (rx_hold_req) begin
                stall       = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Offer one beat after a random gap and hold it until accepted.
    // Leave valid high on return so back-to-back beats never drop it.
    task automatic send_beat(input logic clr, input logic [SMP_W-1:0] smp);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= clr;
        do @(posedge clk); while (!s_tready);
        n_beats++;
        if (clr) n_clears++;
    endtask

    // Drop valid and wait until every expected result has been taken,
    // then let the sequencer fall back to idle. Wait for a clock edge first so
    // the pending count already includes the beat accepted last.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Setup phase, access phase, then an idle phase so writes never abut.
    // Junk in the upper data bits must be ignored by the block.
    task automatic reg_write(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        n_reg_writes++;
    endtask

    task automatic retune(input logic [CFG_W-1:0] cut, input logic [CFG_W-1:0] fbg);
        drain();
        reg_write(REG_CUTOFF, cut);
        reg_write(REG_GAIN, fbg);
    endtask

    initial begin : stimulus
        logic [SMP_W-1:0] smp;
        logic [SMP_W-1:0] last_smp;
        logic             clr;
        logic [CFG_W-1:0] cut;
        logic [CFG_W-1:0] fbg;
        int               per_setting;

        // Hold reset low, then release
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-scale steps at reset coefficients, fast poles
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (4) send_beat(1'b0, 16'h7FFF);
        repeat (3) send_beat(1'b0, 16'h8000);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b1, 16'h7FFF);

        // Fastest poles with maximum resonance: drive the poles into saturation
        retune(16'hFFFF, 16'hFFFF);
        repeat (3) send_beat(1'b0, 16'h7FFF);
        repeat (3) send_beat(1'b0, 16'h8000);
        send_beat(1'b1, 16'h8000);

        // Fastest poles without feedback
        retune(16'hFFFF, 16'h0000);
        repeat (2) send_beat(1'b0, 16'h7FFF);
        repeat (2) send_beat(1'b0, 16'h8000);

        // Frozen poles: the poles hold, so the output is the sample minus a fixed stage three
        retune(16'h0000, 16'h0000);
        send_beat(1'b0, 16'h8000);
        send_beat(1'b0, 16'h7FFF);
        send_beat(1'b0, 16'h0001);
        send_beat(1'b1, 16'h0000);

        // Random beats over a sweep of settings, reset values and extremes first
        per_setting = RAND_BEATS / N_SETTINGS;
        last_smp    = '0;
        for (int p = 0; p < N_SETTINGS; p++) begin
            case (p)
                0: begin cut = CUTOFF_RESET; fbg = GAIN_RESET; end
                1: begin cut = 16'hFFFF;     fbg = 16'hFFFF;   end
                2: begin cut = 16'h0000;     fbg = 16'hFFFF;   end
                3: begin cut = 16'hFFFF;     fbg = 16'h0000;   end
                default: begin
                    cut = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4096));
                    fbg = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8192));
                end
            endcase
            retune(cut, fbg);
            for (int k = 0; k < per_setting; k++) begin
                // Redraw idle behavior now and then, with fully busy stretches
                if (k % 64 == 0) begin
                    tx_steady = ($urandom_range(0, 3) == 0);
                    rx_steady = ($urandom_range(0, 3) == 0);
                end
                // Starve the output while input keeps coming
                if ((p == 1 || p == 4) && k == 40) rx_hold_req = 1'b1;
                // Pause the input until everything has come out
                if (k == 100) drain();
                clr = ($urandom_range(0, 39) == 0);
                case ($urandom_range(0, 4))
                    0: smp = 16'($urandom);
                    1: smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    2: smp = 16'($signed(17'($urandom_range(0, 511))) - 17'sd256);
                    3: smp = last_smp;
                    default: smp = -last_smp;
                endcase
                send_beat(clr, smp);
                last_smp = smp;
            end
        end

        drain();
        $display("covered %0d beats (%0d clears) over %0d filter settings, %0d register writes",
                 n_beats, n_clears, N_SETTINGS + 4, n_reg_writes);
        $display("checked %0d results, including a long output stall and input drains",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_resonant_cascade_highpass_filter_unit OK");
        end else begin
            $display("tb_resonant_cascade_highpass_filter_unit NOT OK");
        end
        $finish;
    end

endmodule
